// ===== rtl/arf_pkg.sv =====
package arf_pkg;

    localparam int MAX_LEN_DEF         = 1024;
    localparam int RESIDUAL_BITS_DEF   = 24;
    localparam int OMEGA_FRAC_BITS_DEF = 16;

    localparam int ACC_BITS     = 64;
    localparam int COUNT_BITS   = 16;
    localparam int CAP_SHIFT    = 40;
    localparam int WS_BITS      = 42;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [1:0] {
        KIND_ELEM,
        KIND_LAST,
        KIND_CLEAR
    } kind_t;

    typedef enum logic [1:0] {
        REG_OMEGA_INITIAL = 2'd0,
        REG_OMEGA_MIN     = 2'd1,
        REG_OMEGA_MAX     = 2'd2,
        REG_DESCENT_LIMIT = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_FIN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_QUOT,
        ST_CLAMP,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/arf_ram.sv =====
module arf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/arf_front.sv =====
module arf_front #(
    parameter int RESIDUAL_BITS = arf_pkg::RESIDUAL_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic                     action,
    input  logic [RESIDUAL_BITS-1:0] residual,
    input  logic                     last,
    output logic                     q_valid,
    output arf_pkg::kind_t           q_kind,
    output logic [RESIDUAL_BITS-1:0] q_residual,
    input  logic                     q_pop
);

    localparam int DEPTH    = arf_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    arf_pkg::kind_t           kind_mem [DEPTH];
    logic [RESIDUAL_BITS-1:0] res_mem  [DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    arf_pkg::kind_t      kind_in;
    logic                push;
    logic                pop;

    always_comb
    begin
        case ({action, last})
            2'b00:   kind_in = arf_pkg::KIND_ELEM;
            2'b01:   kind_in = arf_pkg::KIND_LAST;
            default: kind_in = arf_pkg::KIND_CLEAR;
        endcase
    end

    assign item_ready = (count_reg != CNT_BITS'(DEPTH));
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_kind     = kind_mem[rd_ptr_reg];
    assign q_residual = res_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_mem[wr_ptr_reg] <= kind_in;
            res_mem[wr_ptr_reg]  <= residual;
        end
    end

endmodule

// ===== rtl/arf_back.sv =====
module arf_back #(
    parameter int MAX_LEN         = arf_pkg::MAX_LEN_DEF,
    parameter int RESIDUAL_BITS   = arf_pkg::RESIDUAL_BITS_DEF,
    parameter int OMEGA_FRAC_BITS = arf_pkg::OMEGA_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  arf_pkg::kind_t                    q_kind,
    input  logic [RESIDUAL_BITS-1:0]          q_residual,
    output logic                              q_pop,
    input  logic [OMEGA_FRAC_BITS+1:0]        omega_initial,
    input  logic [OMEGA_FRAC_BITS+1:0]        omega_min,
    input  logic [OMEGA_FRAC_BITS+1:0]        omega_max,
    input  logic [OMEGA_FRAC_BITS:0]          descent_limit,
    output logic                              mem_we,
    output logic [$clog2(MAX_LEN)-1:0]        mem_waddr,
    output logic [RESIDUAL_BITS-1:0]          mem_wdata,
    output logic [$clog2(MAX_LEN)-1:0]        mem_raddr,
    input  logic [RESIDUAL_BITS-1:0]          mem_rdata,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [OMEGA_FRAC_BITS+1:0]        omega,
    output logic                              first_of_step,
    output logic [arf_pkg::COUNT_BITS-1:0]    corrector_count,
    output logic [OMEGA_FRAC_BITS+1:0]        omega_min_seen,
    output logic [OMEGA_FRAC_BITS+1:0]        omega_max_seen,
    output logic                              overflow
);

    localparam int OW   = OMEGA_FRAC_BITS + 2;
    localparam int LW   = OMEGA_FRAC_BITS + 1;
    localparam int IW   = $clog2(MAX_LEN + 1);
    localparam int AW   = $clog2(MAX_LEN);
    localparam int DW   = RESIDUAL_BITS + 1;
    localparam int SQW  = 2 * DW;
    localparam int CRW  = RESIDUAL_BITS + DW;
    localparam int AB   = arf_pkg::ACC_BITS;
    localparam int HB   = AB / 2;
    localparam int PW   = OW + AB;
    localparam int DCW  = $clog2(PW);
    localparam int CS   = arf_pkg::CAP_SHIFT;
    localparam int WSB  = arf_pkg::WS_BITS;
    localparam int CB   = arf_pkg::COUNT_BITS;
    localparam logic [OW-1:0] LOW_RST = OW'(64'd1 << OMEGA_FRAC_BITS);

    arf_pkg::state_t state_reg, state_next;
    arf_pkg::kind_t  kind_reg, kind_next;
    logic [RESIDUAL_BITS-1:0] res_reg, res_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   prev_len_reg, prev_len_next;
    logic            hist_reg, hist_next;
    logic            ovf_reg, ovf_next;
    logic [AB-1:0]   den_reg, den_next;
    logic signed [AB-1:0] num_reg, num_next;
    logic [OW-1:0]   omega_prev_reg, omega_prev_next;
    logic [CB-1:0]   count_reg, count_next;
    logic [OW-1:0]   low_reg, low_next;
    logic [OW-1:0]   high_reg, high_next;
    logic            res_valid_reg, res_valid_next;
    logic [DCW-1:0]  dcnt_reg, dcnt_next;

    logic [SQW-1:0]  sq_reg, sq_next;
    logic signed [CRW-1:0] cross_reg, cross_next;
    logic [OW-1:0]   w_reg, w_next;
    logic            seed_reg, seed_next;
    logic [OW:0]     lim_reg, lim_next;
    logic [OW+HB-1:0] plo_reg, plo_next;
    logic [PW-1:0]   quo_reg, quo_next;
    logic [AB:0]     rem_reg, rem_next;
    logic signed [WSB-1:0] ws_reg, ws_next;
    logic [OW-1:0]   o_omega_reg, o_omega_next;
    logic            o_first_reg, o_first_next;
    logic [CB-1:0]   o_count_reg, o_count_next;
    logic [OW-1:0]   o_low_reg, o_low_next;
    logic [OW-1:0]   o_high_reg, o_high_next;
    logic            o_ovf_reg, o_ovf_next;

    logic [OW-1:0]   seed_w;
    logic signed [DW-1:0] dr;
    logic [DW-1:0]   mag;
    logic [AB:0]     den_sum;
    logic signed [AB:0] num_sum;
    logic [AB-1:0]   nabs;
    logic [OW-1:0]   wm;
    logic [OW+HB-1:0] phi;
    logic [LW+OW-1:0] lim_prod;
    logic [AB:0]     trial;
    logic            qbit;
    logic            q_big;
    logic [CS:0]     qsat;
    logic signed [WSB-1:0] ws_lim;
    logic signed [WSB-1:0] min_s;
    logic signed [WSB-1:0] max_s;
    logic signed [WSB-1:0] lim_s;

    always_comb
    begin
        seed_w = (omega_initial < omega_max) ? omega_initial : omega_max;
        seed_w = (seed_w > omega_min) ? seed_w : omega_min;
    end

    assign dr   = $signed({res_reg[RESIDUAL_BITS-1], res_reg})
                - $signed({mem_rdata[RESIDUAL_BITS-1], mem_rdata});
    assign mag  = dr[DW-1] ? DW'(-dr) : DW'(dr);
    assign nabs = num_reg[AB-1] ? AB'(-num_reg) : AB'(num_reg);
    assign wm   = (omega_prev_reg == '0) ? OW'(1) : omega_prev_reg;
    assign phi  = wm * nabs[AB-1:HB];
    assign lim_prod = descent_limit * omega_prev_reg;
    assign den_sum  = {1'b0, den_reg} + (AB + 1)'(sq_reg);
    assign num_sum  = {num_reg[AB-1], num_reg} + (AB + 1)'(cross_reg);
    assign trial    = {rem_reg[AB-1:0], quo_reg[PW-1]};
    assign qbit     = (trial >= {1'b0, den_reg});
    assign q_big    = (|quo_reg[PW-1:CS+1]) || (quo_reg[CS] && (|quo_reg[CS-1:0]));
    assign qsat     = q_big ? (CS + 1)'(1) << CS
                            : ((omega_prev_reg == '0) ? '0 : quo_reg[CS:0]);
    assign min_s    = $signed(WSB'(omega_min));
    assign max_s    = $signed(WSB'(omega_max));
    assign lim_s    = $signed(WSB'(lim_reg));
    assign ws_lim   = ((descent_limit != '0) && (ws_reg < lim_s)) ? lim_s : ws_reg;

    assign mem_raddr = idx_reg[AW-1:0];
    assign mem_waddr = idx_reg[AW-1:0];
    assign mem_wdata = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        res_next        = res_reg;
        idx_next        = idx_reg;
        prev_len_next   = prev_len_reg;
        hist_next       = hist_reg;
        ovf_next        = ovf_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        omega_prev_next = omega_prev_reg;
        count_next      = count_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        res_valid_next  = res_valid_reg && !result_ready;
        dcnt_next       = dcnt_reg;
        sq_next         = sq_reg;
        cross_next      = cross_reg;
        w_next          = w_reg;
        seed_next       = seed_reg;
        lim_next        = lim_reg;
        plo_next        = plo_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        ws_next         = ws_reg;
        o_omega_next    = o_omega_reg;
        o_first_next    = o_first_reg;
        o_count_next    = o_count_reg;
        o_low_next      = o_low_reg;
        o_high_next     = o_high_reg;
        o_ovf_next      = o_ovf_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;

        case (state_reg)
            arf_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    kind_next = q_kind;
                    res_next  = q_residual;
                    if (q_kind == arf_pkg::KIND_CLEAR)
                    begin
                        hist_next       = 1'b0;
                        prev_len_next   = '0;
                        omega_prev_next = seed_w;
                        count_next      = '0;
                        low_next        = omega_max;
                        high_next       = '0;
                        idx_next        = '0;
                        den_next        = '0;
                        num_next        = '0;
                        ovf_next        = 1'b0;
                    end
                    else if (idx_reg < IW'(MAX_LEN))
                    begin
                        state_next = arf_pkg::ST_READ;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (q_kind == arf_pkg::KIND_LAST)
                        begin
                            state_next = arf_pkg::ST_FIN;
                        end
                    end
                end
            end
            arf_pkg::ST_READ:
            begin
                sq_next    = mag * mag;
                cross_next = $signed(mem_rdata) * dr;
                mem_we     = 1'b1;
                state_next = arf_pkg::ST_ACC;
            end
            arf_pkg::ST_ACC:
            begin
                if (hist_reg && (idx_reg < prev_len_reg))
                begin
                    den_next = den_sum[AB] ? '1 : den_sum[AB-1:0];
                    if (num_sum[AB] != num_sum[AB-1])
                    begin
                        num_next = num_sum[AB] ? {1'b1, {(AB-1){1'b0}}}
                                               : {1'b0, {(AB-1){1'b1}}};
                    end
                    else
                    begin
                        num_next = num_sum[AB-1:0];
                    end
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (kind_reg == arf_pkg::KIND_LAST) ? arf_pkg::ST_FIN
                                                              : arf_pkg::ST_IDLE;
            end
            arf_pkg::ST_FIN:
            begin
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
                lim_next = (OW + 1)'(lim_prod >> OMEGA_FRAC_BITS);
                if (!hist_reg || (idx_reg != prev_len_reg))
                begin
                    seed_next  = 1'b1;
                    w_next     = seed_w;
                    state_next = arf_pkg::ST_DONE;
                end
                else
                begin
                    seed_next = 1'b0;
                    if (den_reg == '0)
                    begin
                        ws_next    = $signed(WSB'(omega_prev_reg));
                        state_next = arf_pkg::ST_CLAMP;
                    end
                    else
                    begin
                        state_next = arf_pkg::ST_MUL_LO;
                    end
                end
            end
            arf_pkg::ST_MUL_LO:
            begin
                plo_next   = wm * nabs[HB-1:0];
                state_next = arf_pkg::ST_MUL_HI;
            end
            arf_pkg::ST_MUL_HI:
            begin
                quo_next   = {phi, {HB{1'b0}}} + PW'(plo_reg);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = arf_pkg::ST_DIV;
            end
            arf_pkg::ST_DIV:
            begin
                rem_next  = qbit ? trial - {1'b0, den_reg} : trial;
                quo_next  = {quo_reg[PW-2:0], qbit};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(PW - 1))
                begin
                    state_next = arf_pkg::ST_QUOT;
                end
            end
            arf_pkg::ST_QUOT:
            begin
                if (num_reg > 0)
                begin
                    ws_next = -$signed(WSB'(qsat));
                end
                else
                begin
                    ws_next = $signed(WSB'(qsat));
                end
                state_next = arf_pkg::ST_CLAMP;
            end
            arf_pkg::ST_CLAMP:
            begin
                if (!(ws_lim > min_s))
                begin
                    w_next = omega_min;
                end
                else if (ws_lim > max_s)
                begin
                    w_next = omega_max;
                end
                else
                begin
                    w_next = ws_lim[OW-1:0];
                end
                state_next = arf_pkg::ST_DONE;
            end
            arf_pkg::ST_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    low_next        = (w_reg < low_reg) ? w_reg : low_reg;
                    high_next       = (w_reg > high_reg) ? w_reg : high_reg;
                    omega_prev_next = w_reg;
                    hist_next       = 1'b1;
                    prev_len_next   = idx_reg;
                    o_omega_next    = w_reg;
                    o_first_next    = seed_reg;
                    o_count_next    = count_reg;
                    o_low_next      = low_next;
                    o_high_next     = high_next;
                    o_ovf_next      = ovf_reg;
                    res_valid_next  = 1'b1;
                    idx_next        = '0;
                    den_next        = '0;
                    num_next        = '0;
                    ovf_next        = 1'b0;
                    state_next      = arf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= arf_pkg::ST_IDLE;
            idx_reg        <= '0;
            prev_len_reg   <= '0;
            hist_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            den_reg        <= '0;
            num_reg        <= '0;
            count_reg      <= '0;
            low_reg        <= LOW_RST;
            high_reg       <= '0;
            res_valid_reg  <= 1'b0;
            dcnt_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            prev_len_reg   <= prev_len_next;
            hist_reg       <= hist_next;
            ovf_reg        <= ovf_next;
            den_reg        <= den_next;
            num_reg        <= num_next;
            count_reg      <= count_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            res_valid_reg  <= res_valid_next;
            dcnt_reg       <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        res_reg        <= res_next;
        omega_prev_reg <= omega_prev_next;
        sq_reg         <= sq_next;
        cross_reg      <= cross_next;
        w_reg          <= w_next;
        seed_reg       <= seed_next;
        lim_reg        <= lim_next;
        plo_reg        <= plo_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        ws_reg         <= ws_next;
        o_omega_reg    <= o_omega_next;
        o_first_reg    <= o_first_next;
        o_count_reg    <= o_count_next;
        o_low_reg      <= o_low_next;
        o_high_reg     <= o_high_next;
        o_ovf_reg      <= o_ovf_next;
    end

    assign result_valid    = res_valid_reg;
    assign omega           = o_omega_reg;
    assign first_of_step   = o_first_reg;
    assign corrector_count = o_count_reg;
    assign omega_min_seen  = o_low_reg;
    assign omega_max_seen  = o_high_reg;
    assign overflow        = o_ovf_reg;

endmodule

// ===== rtl/aitken_relaxation_factor.sv =====
// Channel   Handshake                    Payload
// request   item_valid / item_ready      action, residual, last
// result    result_valid / result_ready  omega, first_of_step, corrector_count,
//                                        omega_min_seen, omega_max_seen, overflow
// config    cfg_we                       cfg_index, cfg_data
//
// In the back end a residual element goes through history read, multiply and accumulate, in that order.
// A final element then computes the factor, using the bit-serial divider when the history matches.
// A history reset request is handled as it is popped from the queue; reset needs no clearing pass.
// A four-entry queue keeps accepting requests, until it is full, while the back end works or the result stalls.
module aitken_relaxation_factor #(
    parameter int MAX_LEN         = arf_pkg::MAX_LEN_DEF,
    parameter int RESIDUAL_BITS   = arf_pkg::RESIDUAL_BITS_DEF,
    parameter int OMEGA_FRAC_BITS = arf_pkg::OMEGA_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              action,
    input  logic [RESIDUAL_BITS-1:0]          residual,
    input  logic                              last,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [OMEGA_FRAC_BITS+1:0]        omega,
    output logic                              first_of_step,
    output logic [arf_pkg::COUNT_BITS-1:0]    corrector_count,
    output logic [OMEGA_FRAC_BITS+1:0]        omega_min_seen,
    output logic [OMEGA_FRAC_BITS+1:0]        omega_max_seen,
    output logic                              overflow,
    input  logic                              cfg_we,
    input  logic [arf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [OMEGA_FRAC_BITS+1:0]        cfg_data
);

    localparam int OW = OMEGA_FRAC_BITS + 2;
    localparam int LW = OMEGA_FRAC_BITS + 1;
    localparam int AW = $clog2(MAX_LEN);
    localparam logic [OW-1:0] INIT_RST = OW'(64'd1 << (OMEGA_FRAC_BITS - 1));
    localparam logic [OW-1:0] MIN_RST  = OW'((64'd6554 << OMEGA_FRAC_BITS) >> 16);
    localparam logic [OW-1:0] MAX_RST  = OW'(64'd1 << OMEGA_FRAC_BITS);

    logic [OW-1:0] omega_initial_reg;
    logic [OW-1:0] omega_min_reg;
    logic [OW-1:0] omega_max_reg;
    logic [LW-1:0] descent_limit_reg;

    logic                     q_valid;
    arf_pkg::kind_t           q_kind;
    logic [RESIDUAL_BITS-1:0] q_residual;
    logic                     q_pop;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [RESIDUAL_BITS-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [RESIDUAL_BITS-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_initial_reg <= INIT_RST;
            omega_min_reg     <= MIN_RST;
            omega_max_reg     <= MAX_RST;
            descent_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (arf_pkg::cfg_reg_t'(cfg_index))
                arf_pkg::REG_OMEGA_INITIAL: omega_initial_reg <= cfg_data;
                arf_pkg::REG_OMEGA_MIN:     omega_min_reg     <= cfg_data;
                arf_pkg::REG_OMEGA_MAX:     omega_max_reg     <= cfg_data;
                arf_pkg::REG_DESCENT_LIMIT: descent_limit_reg <= cfg_data[LW-1:0];
                default:                    omega_max_reg     <= omega_max_reg;
            endcase
        end
    end

    arf_front #(
        .RESIDUAL_BITS (RESIDUAL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .action     (action),
        .residual   (residual),
        .last       (last),
        .q_valid    (q_valid),
        .q_kind     (q_kind),
        .q_residual (q_residual),
        .q_pop      (q_pop)
    );

    arf_ram #(
        .WIDTH (RESIDUAL_BITS),
        .DEPTH (MAX_LEN)
    ) u_hist_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    arf_back #(
        .MAX_LEN         (MAX_LEN),
        .RESIDUAL_BITS   (RESIDUAL_BITS),
        .OMEGA_FRAC_BITS (OMEGA_FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_kind          (q_kind),
        .q_residual      (q_residual),
        .q_pop           (q_pop),
        .omega_initial   (omega_initial_reg),
        .omega_min       (omega_min_reg),
        .omega_max       (omega_max_reg),
        .descent_limit   (descent_limit_reg),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .omega           (omega),
        .first_of_step   (first_of_step),
        .corrector_count (corrector_count),
        .omega_min_seen  (omega_min_seen),
        .omega_max_seen  (omega_max_seen),
        .overflow        (overflow)
    );

endmodule

// ===== rtl/arf_checker.sv =====
module arf_checker #(
    parameter int OMEGA_FRAC_BITS = arf_pkg::OMEGA_FRAC_BITS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic [OMEGA_FRAC_BITS+1:0]     omega,
    input logic [arf_pkg::COUNT_BITS-1:0] corrector_count,
    input logic [OMEGA_FRAC_BITS+1:0]     omega_min_seen,
    input logic [OMEGA_FRAC_BITS+1:0]     omega_max_seen
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(omega) && $stable(corrector_count))
        else $error("result changed while stalled");

    // The reported extremes always bracket the factor they come with.
    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (omega_min_seen <= omega) && (omega <= omega_max_seen))
        else $error("factor outside reported extremes");

    // Every result counts itself.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> corrector_count != '0)
        else $error("corrector count is zero on a result");

endmodule

bind aitken_relaxation_factor arf_checker #(
    .OMEGA_FRAC_BITS (OMEGA_FRAC_BITS)
) u_arf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .omega           (omega),
    .corrector_count (corrector_count),
    .omega_min_seen  (omega_min_seen),
    .omega_max_seen  (omega_max_seen)
);
